// ----- rtl/bfs_parent_order_macros.svh -----
// Assertion macros shared by the RTL
`ifndef BFS_PARENT_ORDER_MACROS_SVH
`define BFS_PARENT_ORDER_MACROS_SVH

// Clocked check, masked while reset is high
`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define BFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bfs_pkg.sv -----
package bfs_pkg;

  // payload widths
  localparam int CHILD_W  = 5;
  localparam int PARENT_W = 6;
  localparam int STATUS_W = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CYCLIC   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SPARSE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  // parent code of a root child
  localparam logic [PARENT_W-1:0] ROOT_ID = 6'h3f;

endpackage

// ----- rtl/bfs_in_if.sv -----
interface bfs_in_if;
  logic                                valid;
  logic                                ready;
  logic [bfs_pkg::CHILD_W-1:0]         child_id;
  logic signed [bfs_pkg::PARENT_W-1:0] parent_id;
  logic                                last;

  modport source (output valid, child_id, parent_id, last, input ready);
  modport sink (input valid, child_id, parent_id, last, output ready);
endinterface

// ----- rtl/bfs_out_if.sv -----
interface bfs_out_if;
  logic                                valid;
  logic                                ready;
  logic [bfs_pkg::CHILD_W-1:0]         node_id;
  logic signed [bfs_pkg::PARENT_W-1:0] node_parent;
  logic [bfs_pkg::STATUS_W-1:0]        status;
  logic                                final_res;

  modport source (output valid, node_id, node_parent, status, final_res, input ready);
  modport sink (input valid, node_id, node_parent, status, final_res, output ready);
endinterface

// ----- rtl/bfs_ram.sv -----
module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bfs_parent_order.sv -----
// Loading: one pair per cycle while idle; results only on the last pair.
// After the last pair: clear, pair count, slot prefix and pair scatter, then two
// walks (check, emit) over the visited nodes and their children; all passes share
// the single offset memory. Range and overflow errors skip these passes and go
// straight to the report. Reset (rst, synchronous) empties the set and the output
// register; memories keep their contents.
`include "bfs_parent_order_macros.svh"

module bfs_parent_order #(
  parameter int MAX_ENTRIES = 32,
  parameter int MAX_NODES   = 32
) (
  input  logic clk,
  input  logic rst,
  bfs_in_if.sink    in_ch,
  bfs_out_if.source out_ch
);

  localparam int EW  = $clog2(MAX_ENTRIES + 1);
  localparam int PAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int QAW = $clog2(MAX_ENTRIES + 1);
  localparam int OAW = $clog2(MAX_NODES + 3);
  localparam int KW  = (OAW > EW) ? OAW : EW;
  localparam int PW  = bfs_pkg::PARENT_W;
  localparam int CW  = bfs_pkg::CHILD_W;
  localparam int SW  = bfs_pkg::STATUS_W;
  localparam logic [KW-1:0] LAST_SLOT = KW'(MAX_NODES + 2);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001, S_CLR   = 17'h00002, S_CNT_A = 17'h00004,
    S_CNT_B = 17'h00008, S_CNT_C = 17'h00010, S_PRE_A = 17'h00020,
    S_PRE_B = 17'h00040, S_SCT_A = 17'h00080, S_SCT_B = 17'h00100,
    S_SCT_C = 17'h00200, S_WQ    = 17'h00400, S_WS    = 17'h00800,
    S_WL    = 17'h01000, S_WJ    = 17'h02000, S_WCHK  = 17'h04000,
    S_WE    = 17'h08000, S_REP   = 17'h10000
  } state_t;

  state_t state, state_next;
  logic [EW-1:0] entry_count, entry_count_next;
  logic [SW-1:0] error_seen, error_seen_next;
  logic [KW-1:0] k, k_next;
  logic [EW-1:0] acc, acc_next;
  logic [OAW-1:0] slot, slot_next;
  logic [CW-1:0] child_r, child_r_next;
  logic [EW-1:0] qi, qi_next, emitted, emitted_next, j, j_next, limit, limit_next;
  logic [PW-1:0] obj, obj_next;
  logic emit, emit_next;

  logic          out_valid;
  logic [CW-1:0] out_node;
  logic [PW-1:0] out_parent;
  logic [SW-1:0] out_status;
  logic          out_final;
  logic          out_load;
  logic [CW-1:0] ld_node;
  logic [PW-1:0] ld_parent;
  logic [SW-1:0] ld_status;
  logic          ld_final;
  logic          can_load;

  // memory ports
  logic             pair_we;
  logic [PAW-1:0]   pair_waddr, pair_raddr;
  logic [CW+PW-1:0] pair_wdata, pair_rdata;
  logic             off_we;
  logic [OAW-1:0]   off_waddr, off_raddr;
  logic [EW-1:0]    off_wdata, off_rdata;
  logic             list_we;
  logic [PAW-1:0]   list_waddr, list_raddr;
  logic [CW-1:0]    list_wdata, list_rdata;
  logic             q_we;
  logic [QAW-1:0]   q_waddr, q_raddr;
  logic [PW-1:0]    q_wdata, q_rdata;

  bfs_ram #(.WIDTH(CW + PW), .DEPTH(MAX_ENTRIES)) u_pair (
    .clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
    .raddr(pair_raddr), .rdata(pair_rdata));
  bfs_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 3)) u_off (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata));
  bfs_ram #(.WIDTH(CW), .DEPTH(MAX_ENTRIES)) u_list (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_rdata));
  bfs_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES + 1)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));

  // input checks
  logic in_bad, in_full;
  logic [PW-1:0] in_par;
  assign in_par  = in_ch.parent_id;
  assign in_bad  = (7'(in_ch.child_id) >= 7'(MAX_NODES))
                || (in_par[PW-1] && (in_par != bfs_pkg::ROOT_ID))
                || (!in_par[PW-1] && (7'(in_par) >= 7'(MAX_NODES)));
  assign in_full = (7'(entry_count) >= 7'(MAX_ENTRIES));
  assign in_ch.ready = (state == S_IDLE);

  // slot of a parent code: parent + add (2 in count and scatter, 1 or 2 in the walk)
  function automatic logic [OAW-1:0] slot_of(input logic [PW-1:0] p, input logic [1:0] add);
    logic [PW:0] s;
    s = {p[PW-1], p} + (PW+1)'(add);
    return s[OAW-1:0];
  endfunction

  assign can_load = !out_valid || out_ch.ready;

  // sequencer
  always_comb begin
    state_next = state;
    entry_count_next = entry_count;
    error_seen_next = error_seen;
    k_next = k;
    acc_next = acc;
    slot_next = slot;
    child_r_next = child_r;
    qi_next = qi;
    emitted_next = emitted;
    j_next = j;
    limit_next = limit;
    obj_next = obj;
    emit_next = emit;
    pair_we = 1'b0;
    pair_waddr = entry_count[PAW-1:0];
    pair_wdata = {in_ch.child_id, in_par};
    pair_raddr = k[PAW-1:0];
    off_we = 1'b0;
    off_waddr = k[OAW-1:0];
    off_wdata = '0;
    off_raddr = k[OAW-1:0];
    list_we = 1'b0;
    list_waddr = off_rdata[PAW-1:0];
    list_wdata = child_r;
    list_raddr = j[PAW-1:0];
    q_we = 1'b0;
    q_waddr = '0;
    q_wdata = bfs_pkg::ROOT_ID;
    q_raddr = qi[QAW-1:0];
    out_load = 1'b0;
    ld_node = '0;
    ld_parent = '0;
    ld_status = error_seen;
    ld_final = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_bad) begin
            if (error_seen == bfs_pkg::ST_OK) error_seen_next = bfs_pkg::ST_RANGE;
          end else if (in_full) begin
            if (error_seen == bfs_pkg::ST_OK) error_seen_next = bfs_pkg::ST_OVERFLOW;
          end else begin
            pair_we = 1'b1;
            entry_count_next = entry_count + EW'(1);
          end
          if (in_ch.last) begin
            k_next = '0;
            state_next = ((error_seen_next != bfs_pkg::ST_OK)) ? S_REP : S_CLR;
          end
        end
      end
      // zero the offsets, seed the queue with the virtual root
      S_CLR: begin
        off_we = 1'b1;
        q_we = (k == '0);
        k_next = k + KW'(1);
        if (k == LAST_SLOT) begin
          k_next = '0;
          state_next = S_CNT_A;
        end
      end
      // count children per parent slot
      S_CNT_A: begin
        if (k == KW'(entry_count)) begin
          k_next = '0;
          acc_next = '0;
          state_next = S_PRE_A;
        end else begin
          state_next = S_CNT_B;
        end
      end
      S_CNT_B: begin
        slot_next = slot_of(pair_rdata[PW-1:0], 2'd2);
        off_raddr = slot_next;
        state_next = S_CNT_C;
      end
      S_CNT_C: begin
        off_we = 1'b1;
        off_waddr = slot;
        off_wdata = off_rdata + EW'(1);
        k_next = k + KW'(1);
        state_next = S_CNT_A;
      end
      // running offsets
      S_PRE_A: state_next = S_PRE_B;
      S_PRE_B: begin
        off_we = 1'b1;
        off_wdata = acc;
        acc_next = acc + off_rdata;
        k_next = k + KW'(1);
        state_next = S_PRE_A;
        if (k == LAST_SLOT) begin
          k_next = '0;
          state_next = S_SCT_A;
        end
      end
      // scatter children into the grouped list
      S_SCT_A: begin
        if (k == KW'(entry_count)) begin
          qi_next = '0;
          emitted_next = '0;
          emit_next = 1'b0;
          state_next = S_WQ;
        end else begin
          state_next = S_SCT_B;
        end
      end
      S_SCT_B: begin
        slot_next = slot_of(pair_rdata[PW-1:0], 2'd2);
        child_r_next = pair_rdata[CW+PW-1:PW];
        off_raddr = slot_next;
        state_next = S_SCT_C;
      end
      S_SCT_C: begin
        list_we = 1'b1;
        off_we = 1'b1;
        off_waddr = slot;
        off_wdata = off_rdata + EW'(1);
        k_next = k + KW'(1);
        state_next = S_SCT_A;
      end
      // breadth-first walk: first a checking pass, then the emitting pass
      S_WQ: begin
        if ((EW+1)'(qi) == (EW+1)'(emitted) + (EW+1)'(1)) begin
          if (emit) begin
            entry_count_next = '0;
            error_seen_next = bfs_pkg::ST_OK;
            state_next = S_IDLE;
          end else if (emitted != entry_count) begin
            error_seen_next = bfs_pkg::ST_SPARSE;
            state_next = S_REP;
          end else begin
            qi_next = '0;
            emitted_next = '0;
            emit_next = 1'b1;
          end
        end else begin
          state_next = S_WS;
        end
      end
      S_WS: begin
        obj_next = q_rdata;
        off_raddr = slot_of(q_rdata, 2'd1);
        state_next = S_WL;
      end
      S_WL: begin
        j_next = off_rdata;
        off_raddr = slot_of(obj, 2'd2);
        state_next = S_WJ;
      end
      S_WJ: begin
        limit_next = off_rdata;
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (j == limit) begin
          qi_next = qi + EW'(1);
          state_next = S_WQ;
        end else if (emitted >= entry_count) begin
          error_seen_next = bfs_pkg::ST_CYCLIC;
          state_next = S_REP;
        end else begin
          state_next = S_WE;
        end
      end
      S_WE: begin
        ld_node = list_rdata;
        ld_parent = obj;
        ld_status = bfs_pkg::ST_OK;
        ld_final = ((EW+1)'(emitted) + (EW+1)'(1) == (EW+1)'(entry_count));
        if (!emit || can_load) begin
          out_load = emit;
          q_we = 1'b1;
          q_waddr = QAW'(emitted + EW'(1));
          q_wdata = PW'(list_rdata);
          emitted_next = emitted + EW'(1);
          j_next = j + EW'(1);
          state_next = S_WCHK;
        end
      end
      // single error result
      S_REP: begin
        if (can_load) begin
          out_load = 1'b1;
          entry_count_next = '0;
          error_seen_next = bfs_pkg::ST_OK;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      error_seen <= bfs_pkg::ST_OK;
      emit <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      entry_count <= entry_count_next;
      error_seen <= error_seen_next;
      emit <= emit_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k <= k_next;
    acc <= acc_next;
    slot <= slot_next;
    child_r <= child_r_next;
    qi <= qi_next;
    emitted <= emitted_next;
    j <= j_next;
    limit <= limit_next;
    obj <= obj_next;
    if (out_load) begin
      out_node <= ld_node;
      out_parent <= ld_parent;
      out_status <= ld_status;
      out_final <= ld_final;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.node_id = out_node;
  assign out_ch.node_parent = out_parent;
  assign out_ch.status = out_status;
  assign out_ch.final_res = out_final;

  // checks
  `BFS_ASSERT(a_count_bound, (7'(entry_count) <= 7'(MAX_ENTRIES)), "pair count beyond capacity")
  `BFS_ASSERT(a_walk_bound, ((state == S_WE) |-> (emitted < entry_count)), "walk overran pair count")
  `BFS_ASSERT(a_err_final, ((out_valid && (out_status != bfs_pkg::ST_OK)) |-> (out_final && (out_node == '0))), "error result not final")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// Scoreboard: keeps a private copy of the pair store and works out the
// breadth-first result sequence (or the one error result) whenever a set is closed.
class order_board;
  typedef struct packed {
    logic [bfs_pkg::CHILD_W-1:0]         node;
    logic signed [bfs_pkg::PARENT_W-1:0] parent;
    logic [bfs_pkg::STATUS_W-1:0]        status;
    logic                                fin;
  } order_entry_t;

  localparam int N_ENTRIES = 32;
  localparam int N_NODES   = 32;

  order_entry_t pending_q[$];
  int unsigned  held_child[N_ENTRIES];
  int           held_parent[N_ENTRIES];
  int unsigned  held_cnt;
  logic [bfs_pkg::STATUS_W-1:0] first_err;
  int unsigned  mismatches;
  int unsigned  checked;
  int unsigned  sets_closed;
  int unsigned  err_sets;

  function new();
    held_cnt    = 0;
    first_err   = bfs_pkg::ST_OK;
    mismatches  = 0;
    checked     = 0;
    sets_closed = 0;
    err_sets    = 0;
  endfunction

  function void push_entry(int unsigned node, int parent,
                           logic [bfs_pkg::STATUS_W-1:0] st, bit fin);
    order_entry_t e;
    e.node   = node[bfs_pkg::CHILD_W-1:0];
    e.parent = parent[bfs_pkg::PARENT_W-1:0];
    e.status = st;
    e.fin    = fin;
    pending_q.push_back(e);
  endfunction

  // Count, prefix, scatter and walk; queues the ordered pairs or one error
  function void walk_hierarchy();
    int          offs[N_NODES+3];
    int unsigned kids[N_ENTRIES];
    int          visit[N_ENTRIES+1];
    order_entry_t walk_q[$];
    order_entry_t e;
    int acc, nxt, slot, obj, lim;
    int unsigned emitted;
    for (int i = 0; i < N_NODES + 3; i++) offs[i] = 0;
    for (int i = 0; i < held_cnt; i++) offs[held_parent[i] + 2]++;
    acc = 0;
    for (int i = 0; i < N_NODES + 3; i++) begin
      nxt = acc + offs[i];
      offs[i] = acc;
      acc = nxt;
    end
    for (int i = 0; i < held_cnt; i++) begin
      slot = held_parent[i] + 2;
      kids[offs[slot]] = held_child[i];
      offs[slot]++;
    end
    emitted = 0;
    visit[0] = -1;
    for (int i = 0; i != emitted + 1; i++) begin
      obj = visit[i];
      lim = offs[obj + 2];
      for (int j = offs[obj + 1]; j != lim; j++) begin
        if (emitted >= held_cnt) begin
          push_entry(0, 0, bfs_pkg::ST_CYCLIC, 1'b1);
          err_sets++;
          return;
        end
        visit[emitted + 1] = kids[j];
        e.node   = kids[j];
        e.parent = obj[bfs_pkg::PARENT_W-1:0];
        e.status = bfs_pkg::ST_OK;
        e.fin    = 1'b0;
        walk_q.push_back(e);
        emitted++;
      end
    end
    if (emitted != held_cnt) begin
      push_entry(0, 0, bfs_pkg::ST_SPARSE, 1'b1);
      err_sets++;
      return;
    end
    if (walk_q.size() > 0) walk_q[walk_q.size()-1].fin = 1'b1;
    foreach (walk_q[k]) pending_q.push_back(walk_q[k]);
  endfunction

  // Accepted input transaction
  function void note_pair(logic [4:0] child, logic signed [5:0] parent, logic last);
    int par;
    par = parent;
    if (child >= N_NODES || par < -1 || par >= N_NODES) begin
      if (first_err == bfs_pkg::ST_OK) first_err = bfs_pkg::ST_RANGE;
    end else if (held_cnt >= N_ENTRIES) begin
      if (first_err == bfs_pkg::ST_OK) first_err = bfs_pkg::ST_OVERFLOW;
    end else begin
      held_child[held_cnt]  = child;
      held_parent[held_cnt] = par;
      held_cnt++;
    end
    if (!last) return;
    sets_closed++;
    if (first_err != bfs_pkg::ST_OK) begin
      push_entry(0, 0, first_err, 1'b1);
      err_sets++;
    end else begin
      walk_hierarchy();
    end
    held_cnt  = 0;
    first_err = bfs_pkg::ST_OK;
  endfunction

  task report(string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Accepted output transaction
  task check_result(order_entry_t got);
    order_entry_t want;
    checked++;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result node=%0d parent=%0d status=%0d",
                       got.node, got.parent, got.status));
      return;
    end
    want = pending_q.pop_front();
    if (got.node !== want.node)
      report($sformatf("node_id %0d, want %0d", got.node, want.node));
    if (got.parent !== want.parent)
      report($sformatf("node_parent %0d, want %0d", got.parent, want.parent));
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.fin !== want.fin)
      report($sformatf("final_res %0d, want %0d", got.fin, want.fin));
  endtask
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 1500;
  localparam int HOLD_CYCLES = 500;

  logic clk;
  logic rst;
  bfs_in_if  in_ch();
  bfs_out_if out_ch();

  bfs_parent_order DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  order_board board;
  int unsigned cyc;
  int unsigned pairs_sent;
  bit idle_on;
  bit hold_req;
  int hold_left;
  int set_c[$];
  int set_p[$];

  // Clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("FAIL bfs_parent_order");
      $finish;
    end
  end

  // Result side ready: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 17);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.node_id, out_ch.node_parent, out_ch.status,
                          out_ch.final_res});
  end

  // One pair, held until the block takes it
  task automatic send_pair(int c, int p, bit l);
    while (idle_on && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.child_id  <= c[4:0];
    in_ch.parent_id <= p[5:0];
    in_ch.last      <= l;
    do @(posedge clk); while (!in_ch.ready);
    board.note_pair(c[4:0], p[5:0], l);
    pairs_sent++;
  endtask

  task automatic send_set();
    for (int i = 0; i < set_c.size(); i++)
      send_pair(set_c[i], set_p[i], i == set_c.size() - 1);
  endtask

  // Valid hierarchy of n distinct nodes, sent in random order
  task automatic make_tree(int n, bit deep);
    int ids[32];
    int a, b, t;
    set_c.delete();
    set_p.delete();
    for (int i = 0; i < 32; i++) ids[i] = i;
    for (int i = 31; i > 0; i--) begin
      a = $urandom_range(i);
      t = ids[i]; ids[i] = ids[a]; ids[a] = t;
    end
    for (int i = 0; i < n; i++) begin
      set_c.push_back(ids[i]);
      if (i == 0 || $urandom_range(5) == 0) set_p.push_back(-1);
      else if (deep) set_p.push_back(ids[i-1]);
      else set_p.push_back(ids[$urandom_range(i-1)]);
    end
    for (int i = n - 1; i > 0; i--) begin
      b = $urandom_range(i);
      t = set_c[i]; set_c[i] = set_c[b]; set_c[b] = t;
      t = set_p[i]; set_p[i] = set_p[b]; set_p[b] = t;
    end
  endtask

  function automatic int pick_size();
    if ($urandom_range(9) == 0) return $urandom_range(28, 32);
    return $urandom_range(1, 8);
  endfunction

  task automatic wait_drained();
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int kind, pos, n;
    board = new();
    cyc = 0;
    pairs_sent = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.child_id = '0;
    in_ch.parent_id = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: lone root child, extreme ids
    send_pair(31, -1, 1'b1);
    send_pair(0, -1, 1'b1);
    // id out of range: most negative parent, then -2
    send_pair(5, -32, 1'b1);
    send_pair(31, 31, 1'b0);
    send_pair(0, -2, 1'b1);
    // self loop under a root child: cyclic
    send_pair(3, -1, 1'b0);
    send_pair(3, 3, 1'b1);
    // unreachable pair: sparse
    send_pair(1, -1, 1'b0);
    send_pair(30, 31, 1'b1);
    // parent with every bit set but -1
    send_pair(7, 31, 1'b0);
    send_pair(31, -1, 1'b1);
    // node listed twice under different parents
    send_pair(1, -1, 1'b0);
    send_pair(2, -1, 1'b0);
    send_pair(2, 1, 1'b1);
    wait_drained();

    // Full-size deep tree and full-size flat set
    make_tree(32, 1'b1);
    send_set();
    set_c.delete(); set_p.delete();
    for (int i = 0; i < 32; i++) begin
      set_c.push_back(31 - i);
      set_p.push_back(-1);
    end
    send_set();
    // Overflow: 33 pairs
    make_tree(32, 1'b0);
    set_c.push_back(0); set_p.push_back(-1);
    send_set();

    // Random sets
    for (int s = 0; pairs_sent < 460; s++) begin
      idle_on = !(s >= 15 && s < 25);
      if (s == 5) hold_req = 1'b1;
      n = pick_size();
      make_tree(n, $urandom_range(3) == 0);
      kind = $urandom_range(99);
      if (kind < 8) begin
        // out of range parent somewhere in the set
        pos = $urandom_range(set_c.size() - 1);
        set_p[pos] = -2 - $urandom_range(30);
      end else if (kind < 14) begin
        // overflow
        while (set_c.size() < 33 + $urandom_range(3)) begin
          set_c.push_back($urandom_range(31));
          set_p.push_back($urandom_range(32) - 1);
        end
      end else if (kind < 20) begin
        // self loop on a loaded node
        pos = $urandom_range(set_c.size() - 1);
        set_c.push_back(set_c[pos]);
        set_p.push_back(set_c[pos]);
      end else if (kind < 26 && n < 31) begin
        // detached two-node loop
        set_c.push_back(31); set_p.push_back(30);
        set_c.insert(0, 30); set_p.insert(0, 31);
        for (int i = 1; i < set_c.size() - 1; i++)
          if (set_c[i] >= 30 || set_p[i] >= 30) begin
            set_c[i] = $urandom_range(29); set_p[i] = -1;
          end
      end else if (kind < 32) begin
        // random noise pairs
        foreach (set_c[i]) begin
          set_c[i] = $urandom_range(31);
          set_p[i] = $urandom_range(63) - 32;
        end
      end
      send_set();
      if (s == 10) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
    end
    in_ch.valid <= 1'b0;
    idle_on = 1'b1;

    // Drain
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d pairs in %0d sets (%0d closing in error), %0d results checked",
             pairs_sent, board.sets_closed, board.err_sets, board.checked);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("PASS bfs_parent_order");
    end else begin
      $display("%0d mismatches, %0d results outstanding", board.mismatches,
               board.pending_q.size());
      $display("FAIL bfs_parent_order");
    end
    $finish;
  end
endmodule
